// ===== hw/rtl/jes_pkg.sv =====
// Shared types and constants for the joint enable sequencer.
package jes_pkg;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CLEAR   = 3'd1,
    ACT_ENABLE  = 3'd2,
    ACT_DISABLE = 3'd3,
    ACT_TORQUE  = 3'd4,
    ACT_ZERO    = 3'd5
  } action_t;

  localparam int ResendWidth    = 10;
  localparam int ClearWidth     = 10;
  localparam int HeartbeatWidth = 12;
  localparam int TimeoutWidth   = 16;
  localparam int CfgDataWidth   = 16;
  localparam int CfgIndexWidth  = 2;

  localparam logic [CfgIndexWidth-1:0] REG_RESEND    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_CLEAR     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_HEARTBEAT = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_TIMEOUT   = 2'd3;

  localparam logic [ResendWidth-1:0]    RESEND_RESET    = 10'd100;
  localparam logic [ClearWidth-1:0]     CLEAR_RESET     = 10'd50;
  localparam logic [HeartbeatWidth-1:0] HEARTBEAT_RESET = 12'd500;
  localparam logic [TimeoutWidth-1:0]   TIMEOUT_RESET   = 16'd1000;

  typedef struct packed {
    logic     fault_held;
    logic     torque_active;
    action_t  joint_action;
    logic     wheel_drive_on;
  } result_t;

endpackage

// ===== hw/rtl/joint_enable_sequencer_unit.sv =====
// Joint enable sequencer: enable request handling, joint action choice and fault latch.
// A request accepted into the input register reaches m_tdata through the result register.
// Throughput: one request per cycle; the whole step is one pass of logic between the input
// register and the result register, and a waiting result holds the input register full.
// Reset (rst, synchronous): all flags and counters clear, the resend counter loads 100 and the
// configuration registers return to 100, 50, 500 and 1000.
module joint_enable_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Fields from bit 0: enable_request, controller_ok, feedback_all_ready, zero padding.
  input  logic [7:0]                          s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: wheel_drive_on, joint_action[2:0], torque_active, fault_held, padding.
  output logic [7:0]                          m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_write,
  input  logic [jes_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [jes_pkg::CfgDataWidth-1:0]    cfg_data
);

  logic [jes_pkg::ResendWidth-1:0]    resend_len;
  logic [jes_pkg::ClearWidth-1:0]     clear_error_cycles;
  logic [jes_pkg::HeartbeatWidth-1:0] heartbeat_cycles;
  logic [jes_pkg::TimeoutWidth-1:0]   enable_timeout_cycles;

  logic                               joints_on, joints_on_next;
  logic                               torque_ever_on, torque_ever_on_next;
  logic                               fault_flag, fault_flag_next;
  logic [jes_pkg::ResendWidth-1:0]    resend_left, resend_left_next;
  logic [jes_pkg::HeartbeatWidth-1:0] heartbeat_count, heartbeat_count_next;
  logic [jes_pkg::TimeoutWidth-1:0]   since_enable, since_enable_next;

  logic [2:0]         in_bits;
  logic               in_valid;
  jes_pkg::result_t   result, result_next;
  logic               out_valid;
  logic               advance;

  logic                               en, ready, change, resending, beat, send_sys;
  logic                               clear_phase, timeout;
  logic                               fault_a, ever_a, joints_a;
  logic [jes_pkg::ResendWidth-1:0]    resend_a, resend_b;
  logic [jes_pkg::HeartbeatWidth-1:0] hb_a, hb_inc;
  logic [jes_pkg::TimeoutWidth-1:0]   since_a;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      resend_len            <= jes_pkg::RESEND_RESET;
      clear_error_cycles    <= jes_pkg::CLEAR_RESET;
      heartbeat_cycles      <= jes_pkg::HEARTBEAT_RESET;
      enable_timeout_cycles <= jes_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        jes_pkg::REG_RESEND:    resend_len <= cfg_data[jes_pkg::ResendWidth-1:0];
        jes_pkg::REG_CLEAR:     clear_error_cycles <= cfg_data[jes_pkg::ClearWidth-1:0];
        jes_pkg::REG_HEARTBEAT: heartbeat_cycles <= cfg_data[jes_pkg::HeartbeatWidth-1:0];
        jes_pkg::REG_TIMEOUT:   enable_timeout_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bits <= s_tdata[2:0];
    end
    if (advance) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      joints_on       <= 1'b0;
      torque_ever_on  <= 1'b0;
      fault_flag      <= 1'b0;
      resend_left     <= jes_pkg::RESEND_RESET;
      heartbeat_count <= '0;
      since_enable    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        joints_on       <= joints_on_next;
        torque_ever_on  <= torque_ever_on_next;
        fault_flag      <= fault_flag_next;
        resend_left     <= resend_left_next;
        heartbeat_count <= heartbeat_count_next;
        since_enable    <= since_enable_next;
      end
    end
  end

  // The enable request is applied first, then one joint action is chosen.
  always_comb begin
    en    = in_bits[0];
    ready = in_bits[1] && in_bits[2];

    fault_a  = en ? fault_flag : 1'b0;
    ever_a   = en ? torque_ever_on : 1'b0;
    change   = !(en && fault_flag) && (en != joints_on);
    joints_a = change ? en : joints_on;
    since_a  = (change && en) ? '0 : since_enable;
    resend_a = change ? resend_len : resend_left;
    hb_a     = change ? '0 : heartbeat_count;

    resending = (resend_a != '0);
    hb_inc    = hb_a + jes_pkg::HeartbeatWidth'(1'b1);
    beat      = !resending && (hb_inc >= heartbeat_cycles);
    send_sys  = resending || beat;

    clear_phase = resending && (({1'b0, resend_a} + {1'b0, clear_error_cycles})
                                > {1'b0, resend_len});
    timeout     = since_a > enable_timeout_cycles;

    joints_on_next       = joints_a;
    fault_flag_next      = fault_a;
    torque_ever_on_next  = ever_a;
    resend_b             = resend_a;
    heartbeat_count_next = resending ? hb_a : (beat ? '0 : hb_inc);
    result_next.wheel_drive_on = joints_a;
    result_next.joint_action   = jes_pkg::ACT_NONE;
    result_next.torque_active  = 1'b0;

    if (joints_a) begin
      if (clear_phase) begin
        result_next.joint_action = jes_pkg::ACT_CLEAR;
      end else if (send_sys) begin
        result_next.joint_action = jes_pkg::ACT_ENABLE;
      end else if (ready) begin
        result_next.joint_action  = jes_pkg::ACT_TORQUE;
        result_next.torque_active = 1'b1;
        torque_ever_on_next       = 1'b1;
      end else if (ever_a || timeout) begin
        fault_flag_next          = 1'b1;
        joints_on_next           = 1'b0;
        resend_b                 = resend_len;
        heartbeat_count_next     = '0;
        result_next.joint_action = jes_pkg::ACT_DISABLE;
      end else begin
        result_next.joint_action = jes_pkg::ACT_ZERO;
      end
      // A heartbeat outside the resend window still lets torque run.
      if (beat && ready) begin
        result_next.torque_active = 1'b1;
        torque_ever_on_next       = 1'b1;
      end
    end else if (send_sys) begin
      result_next.joint_action = jes_pkg::ACT_DISABLE;
    end

    result_next.fault_held = fault_flag_next;
    resend_left_next  = (resend_b != '0) ? resend_b - jes_pkg::ResendWidth'(1'b1) : resend_b;
    since_enable_next = (&since_a) ? since_a : since_a + jes_pkg::TimeoutWidth'(1'b1);
  end

endmodule
